>>> rtl/pcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_pkg: shared types and constants for the polygon convexity checker
// Default coordinate width and the vertex count codes.
// ----------------------------------------------------------------------------
package pcc_pkg;

	// default width of one coordinate (Q8.8)
	localparam int COORD_BITS_DEF = 16;

	// vertices seen in the current polygon, saturating at three
	typedef logic [1:0] seen_t;

	localparam seen_t SEEN_NONE = 2'd0;
	localparam seen_t SEEN_ONE  = 2'd1;
	localparam seen_t SEEN_TWO  = 2'd2;
	localparam seen_t SEEN_FULL = 2'd3;

endpackage

>>> rtl/pcc_vertex_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_vertex_if: vertex channel
// Valid/ready channel carrying one polygon vertex per item.
// ----------------------------------------------------------------------------
interface pcc_vertex_if
	import pcc_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] vertex_x;
	logic signed [COORD_BITS-1:0] vertex_y;
	logic                         final_vertex;

	modport source (output valid, output vertex_x, output vertex_y, output final_vertex,
		input ready);
	modport sink (input valid, input vertex_x, input vertex_y, input final_vertex,
		output ready);
endinterface

>>> rtl/pcc_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_result_if: result channel
// Valid/ready channel carrying one convexity verdict per polygon.
// ----------------------------------------------------------------------------
interface pcc_result_if;
	logic valid;
	logic ready;
	logic convex;
	logic enough_vertices;

	modport source (output valid, output convex, output enough_vertices, input ready);
	modport sink (input valid, input convex, input enough_vertices, output ready);
endinterface

>>> rtl/pcc_edge_cross.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_edge_cross: registered cross product terms of edge vectors a and b
// Forms a.x*b.y and a.y*b.x and holds them in a register.
// ----------------------------------------------------------------------------
module pcc_edge_cross #(
	parameter int DIFF_BITS = 17
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [DIFF_BITS-1:0]   a_x,
	input  logic signed [DIFF_BITS-1:0]   a_y,
	input  logic signed [DIFF_BITS-1:0]   b_x,
	input  logic signed [DIFF_BITS-1:0]   b_y,
	output logic signed [2*DIFF_BITS-1:0] prod_l_s2,
	output logic signed [2*DIFF_BITS-1:0] prod_r_s2
);

	logic signed [2*DIFF_BITS-1:0] prod_l;
	logic signed [2*DIFF_BITS-1:0] prod_r;

	assign prod_l = (2*DIFF_BITS)'(a_x) * (2*DIFF_BITS)'(b_y);
	assign prod_r = (2*DIFF_BITS)'(a_y) * (2*DIFF_BITS)'(b_x);

	// hold the terms while the stage is stalled
	always_ff @(posedge clk) begin
		if (en) begin
			prod_l_s2 <= prod_l;
			prod_r_s2 <= prod_r;
		end
	end

endmodule

>>> rtl/polygon_convexity_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_convexity_check: cross product sign test over a vertex stream
// Classes every turn of the polygon, including the two wrap-around turns
// at the last vertex, and reports whether all turns share one direction.
// ----------------------------------------------------------------------------
//
//  channel    | dir | payload                              | item
//  -----------+-----+--------------------------------------+---------------------
//  vertex_in  | in  | vertex_x, vertex_y, final_vertex     | one vertex
//  result_out | out | convex, enough_vertices              | one per final vertex
//
// One vertex is accepted every cycle while vertex_in.ready is high. The
// accepting edge loads the edge differences (s1), s2 then takes the multiplier
// products, and the signed compare of s2 loads the result register, so a
// result is valid once its final vertex has passed through s1 and s2.
// Reset clears the vertex count, the pipeline valid bits, the turn class and
// the result valid bit. Only a final-vertex item waits in s2, and only while
// the previous result still waits on result_out.ready; one more item can
// enter s1 behind it, then vertex_in.ready drops until the result is taken.
//
module polygon_convexity_check
	import pcc_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	pcc_vertex_if.sink    vertex_in,
	pcc_result_if.source  result_out
);

	localparam int DW = COORD_BITS + 1;  // width of an edge difference
	localparam int PW = 2 * DW;          // width of a product term

	// ---------------------------------------------------------------- control
	logic in_acc;
	logic s1_v_q, s2_v_q, res_v_q;
	logic s1_to_s2, s2_go, s2_free, s1_free;
	logic s1_last_s1, s2_last_s2;
	seen_t s1_cnt_s1, s2_cnt_s2;

	// ---------------------------------------------------- vertex history
	seen_t seen_q;
	logic signed [COORD_BITS-1:0] first_x_q, first_y_q, second_x_q, second_y_q;
	logic signed [COORD_BITS-1:0] older_x_q, older_y_q, newer_x_q, newer_y_q;

	// incoming vertex and history, widened by one bit for exact differences
	logic signed [DW-1:0] vx_e, vy_e, fx_e, fy_e, sx_e, sy_e, ox_e, oy_e, nx_e, ny_e;

	// edge vectors: d0 older->newer, d1 newer->v, d2 v->first, d3 first->second
	logic signed [DW-1:0] d0x_s1, d0y_s1, d1x_s1, d1y_s1;
	logic signed [DW-1:0] d2x_s1, d2y_s1, d3x_s1, d3y_s1;

	logic signed [PW-1:0] p0l_s2, p0r_s2, p1l_s2, p1r_s2, p2l_s2, p2r_s2;

	// ------------------------------------------------------------ classing
	logic ref_q, conv_q;
	logic pos0, pos1, pos2, ref_eff, has_triple, conv_next;
	logic convex_q, enough_q;

	// ------------------------------------------------------------ handshake
	// s2 holds a final-vertex item until the result register can take it
	assign s2_go    = s2_v_q && (!s2_last_s2 || !res_v_q || result_out.ready);
	assign s2_free  = !s2_v_q || s2_go;
	assign s1_to_s2 = s1_v_q && s2_free;
	assign s1_free  = !s1_v_q || s1_to_s2;

	assign vertex_in.ready = s1_free;
	assign in_acc          = vertex_in.valid && vertex_in.ready;

	assign result_out.valid           = res_v_q;
	assign result_out.convex          = convex_q;
	assign result_out.enough_vertices = enough_q;

	// ------------------------------------------------------ vertex history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= SEEN_NONE;
		end else if (in_acc) begin
			if (vertex_in.final_vertex) begin
				// clear for the next polygon
				seen_q <= SEEN_NONE;
			end else if (seen_q != SEEN_FULL) begin
				seen_q <= seen_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (seen_q == SEEN_NONE) begin
				first_x_q <= vertex_in.vertex_x;
				first_y_q <= vertex_in.vertex_y;
			end
			if (seen_q == SEEN_ONE) begin
				second_x_q <= vertex_in.vertex_x;
				second_y_q <= vertex_in.vertex_y;
			end
			older_x_q <= newer_x_q;
			older_y_q <= newer_y_q;
			newer_x_q <= vertex_in.vertex_x;
			newer_y_q <= vertex_in.vertex_y;
		end
	end

	// ------------------------------------------------------ stage 1: edges
	assign vx_e = {vertex_in.vertex_x[COORD_BITS-1], vertex_in.vertex_x};
	assign vy_e = {vertex_in.vertex_y[COORD_BITS-1], vertex_in.vertex_y};
	assign fx_e = {first_x_q[COORD_BITS-1], first_x_q};
	assign fy_e = {first_y_q[COORD_BITS-1], first_y_q};
	assign sx_e = {second_x_q[COORD_BITS-1], second_x_q};
	assign sy_e = {second_y_q[COORD_BITS-1], second_y_q};
	assign ox_e = {older_x_q[COORD_BITS-1], older_x_q};
	assign oy_e = {older_y_q[COORD_BITS-1], older_y_q};
	assign nx_e = {newer_x_q[COORD_BITS-1], newer_x_q};
	assign ny_e = {newer_y_q[COORD_BITS-1], newer_y_q};

	always_ff @(posedge clk) begin
		if (in_acc) begin
			d0x_s1     <= nx_e - ox_e;
			d0y_s1     <= ny_e - oy_e;
			d1x_s1     <= vx_e - nx_e;
			d1y_s1     <= vy_e - ny_e;
			d2x_s1     <= fx_e - vx_e;
			d2y_s1     <= fy_e - vy_e;
			d3x_s1     <= sx_e - fx_e;
			d3y_s1     <= sy_e - fy_e;
			s1_cnt_s1  <= seen_q;
			s1_last_s1 <= vertex_in.final_vertex;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			s2_v_q <= 1'b0;
		end else begin
			if (s1_free) begin
				s1_v_q <= in_acc;
			end
			if (s2_free) begin
				s2_v_q <= s1_to_s2;
			end
		end
	end

	// --------------------------------------------------- stage 2: products
	// the newest turn, then the two wrap-around turns
	pcc_edge_cross #(.DIFF_BITS(DW)) u_cross_turn (
		.clk       (clk),
		.en        (s1_to_s2),
		.a_x       (d0x_s1),
		.a_y       (d0y_s1),
		.b_x       (d1x_s1),
		.b_y       (d1y_s1),
		.prod_l_s2 (p0l_s2),
		.prod_r_s2 (p0r_s2)
	);

	pcc_edge_cross #(.DIFF_BITS(DW)) u_cross_wrap_a (
		.clk       (clk),
		.en        (s1_to_s2),
		.a_x       (d1x_s1),
		.a_y       (d1y_s1),
		.b_x       (d2x_s1),
		.b_y       (d2y_s1),
		.prod_l_s2 (p1l_s2),
		.prod_r_s2 (p1r_s2)
	);

	pcc_edge_cross #(.DIFF_BITS(DW)) u_cross_wrap_b (
		.clk       (clk),
		.en        (s1_to_s2),
		.a_x       (d2x_s1),
		.a_y       (d2y_s1),
		.b_x       (d3x_s1),
		.b_y       (d3y_s1),
		.prod_l_s2 (p2l_s2),
		.prod_r_s2 (p2r_s2)
	);

	always_ff @(posedge clk) begin
		if (s1_to_s2) begin
			s2_cnt_s2  <= s1_cnt_s1;
			s2_last_s2 <= s1_last_s1;
		end
	end

	// ---------------------------------------------- stage 3: class and verdict
	// a zero cross product counts as non-positive
	always_comb begin
		pos0       = p0l_s2 > p0r_s2;
		pos1       = p1l_s2 > p1r_s2;
		pos2       = p2l_s2 > p2r_s2;
		has_triple = (s2_cnt_s2 == SEEN_TWO) || (s2_cnt_s2 == SEEN_FULL);
		// the first turn of the polygon sets the reference class
		ref_eff    = (s2_cnt_s2 == SEEN_TWO) ? pos0 : ref_q;
		conv_next  = conv_q && ((s2_cnt_s2 != SEEN_FULL) || (pos0 == ref_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q  <= 1'b0;
			conv_q <= 1'b1;
		end else if (s2_go) begin
			if (s2_last_s2) begin
				ref_q  <= 1'b0;
				conv_q <= 1'b1;
			end else if (has_triple) begin
				ref_q  <= ref_eff;
				conv_q <= conv_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (s2_go && s2_last_s2) begin
			res_v_q <= 1'b1;
		end else if (result_out.ready) begin
			res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go && s2_last_s2) begin
			// short polygons report convex without enough vertices
			convex_q <= has_triple ? (conv_next && (pos1 == ref_eff) && (pos2 == ref_eff))
				: 1'b1;
			enough_q <= has_triple;
		end
	end

`ifndef NO_ASSERTIONS
	// a short polygon always reports convex
	a_short_is_convex: assert property (@(posedge clk) disable iff (!arst_n)
		(res_v_q && !enough_q) |-> convex_q)
		else $error("short polygon reported non-convex");

	// a final vertex restarts the vertex count
	a_final_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && vertex_in.final_vertex) |=> (seen_q == SEEN_NONE))
		else $error("vertex count not cleared after final vertex");

	// a verdict never overwrites a result still waiting
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_go && s2_last_s2) |-> (!res_v_q || result_out.ready))
		else $error("result overwritten while stalled");

	// the class state is back at its start value after a verdict
	a_class_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_go && s2_last_s2) |=> (conv_q && !ref_q))
		else $error("turn class not cleared after verdict");
`endif

endmodule
